// ===== rtl/core/lirs_pkg.sv =====
// Shared types and constants for the linear interpolation resampler.
// Holds the payload structs, the register indexes and the fixed widths.
// No dependencies.
package lirs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int RATE_W      = 18;
  localparam int PHASE_W     = 19;
  localparam int MAX_RUN     = 64;
  localparam int CNT_W       = $clog2(MAX_RUN + 1);
  localparam int CFG_IDX_W   = 1;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RATE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_input;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          run_last;
    logic                          stream_done;
  } out_item_t;

endpackage

// ===== rtl/core/lirs_div.sv =====
// Iterative restoring divider: frac = round(phase * 2^FRAC_BITS / rate).
// One quotient bit per cycle, FRAC_BITS + 1 quotient bits per division.
// Depends on lirs_pkg for the phase and rate widths.
module lirs_div #(
  parameter int FRAC_BITS = lirs_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lirs_pkg::PHASE_W-1:0] phase,
  input  logic [lirs_pkg::RATE_W-1:0]  rate,
  output logic                         done,
  output logic [FRAC_BITS:0]           quot
);

  localparam int DW    = lirs_pkg::PHASE_W + FRAC_BITS;
  localparam int RW    = lirs_pkg::RATE_W;
  localparam int STEPS = FRAC_BITS + 1;
  localparam int CW    = $clog2(STEPS + 1);

  logic [DW-1:0]    dvd;
  logic [RW-1:0]    rem;
  logic [FRAC_BITS:0] low;
  logic [RW-1:0]    dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [RW:0]      trial;
  logic [RW:0]      diff;
  logic             qbit;

  // Phase is below rate while dividing, so the top bits start below the divisor.
  assign dvd   = {phase, {FRAC_BITS{1'b0}}} + DW'(rate >> 1);
  assign trial = {rem, low[FRAC_BITS]};
  assign diff  = trial - {1'b0, dsr};
  assign qbit  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(STEPS);
        rem  <= dvd[DW-1:FRAC_BITS+1];
        low  <= dvd[FRAC_BITS:0];
        dsr  <= rate;
      end else if (busy) begin
        rem  <= qbit ? diff[RW-1:0] : trial[RW-1:0];
        low  <= {low[FRAC_BITS-1:0], 1'b0};
        quot <= {quot[FRAC_BITS-1:0], qbit};
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/linear_interp_resampler_core.sv =====
// Linear interpolation sample rate converter, top level.
// Per interpolated output the sequencer steps through ST_RUN, ST_DIV (waiting on the
// bit-serial divider), ST_RND and ST_PUSH; a skipped phase step is one pass through ST_RUN
// or ST_TAIL, a tail copy ST_TAIL then ST_PUSH. One input item is worked at a time; the
// run's last output is held back and offered from ST_FLUSH.
// Reset (rst, synchronous, active high) returns rates to 48000 and clears stream state.
module linear_interp_resampler_core #(
  parameter int FRAC_BITS = lirs_pkg::FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lirs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lirs_pkg::RATE_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lirs_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lirs_pkg::out_item_t               out_data
);

  localparam int S  = lirs_pkg::SAMPLE_BITS;
  localparam int PW = S + FRAC_BITS + 2;
  localparam int PH = lirs_pkg::PHASE_W;
  localparam int RW = lirs_pkg::RATE_W;
  localparam int NW = lirs_pkg::CNT_W;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_DIV, ST_RND, ST_PUSH, ST_TAIL, ST_FLUSH
  } state_t;

  state_t state;

  // Rate registers
  logic [RW-1:0] src_rate;
  logic [RW-1:0] dst_rate;
  logic [RW-1:0] rin;
  logic [RW-1:0] rout;

  // Stream state
  logic [PH-1:0]         phase;
  logic signed [S-1:0]   prev;
  logic                  have_prev;

  // Per-item working registers
  logic signed [S-1:0]   cur;
  logic                  eos;
  logic signed [S:0]     diff;
  logic signed [PW-1:0]  prod;
  logic [NW-1:0]         res_count;
  logic signed [S-1:0]   nv_sample;
  logic                  in_tail;

  // One result is held back until we know whether it closes the run.
  logic                  hold_valid;
  logic signed [S-1:0]   hold_sample;

  logic                  div_start;
  logic                  div_done;
  logic [FRAC_BITS:0]    div_quot;

  logic                  in_xfer;
  logic                  out_free;
  logic                  emit;
  logic                  below;
  logic                  room;
  logic [PH-1:0]         phase_step;
  logic signed [PW-1:0]  rsum;
  logic signed [PW-1:0]  rshift;

  // A zero rate behaves as one.
  assign rin  = (src_rate == '0) ? RW'(1) : src_rate;
  assign rout = (dst_rate == '0) ? RW'(1) : dst_rate;

  assign in_stall   = (state != ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  // Load the output register from the held result in push or flush.
  assign emit       = hold_valid && out_free &&
                      ((state == ST_PUSH) || (state == ST_FLUSH));
  assign below      = (phase < PH'(rout));
  assign room       = (res_count < NW'(lirs_pkg::MAX_RUN));
  assign phase_step = phase + PH'(rin);
  assign div_start  = (state == ST_RUN) && below && room;
  assign rsum       = prod + HALF;
  assign rshift     = rsum >>> FRAC_BITS;

  lirs_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .phase (phase),
    .rate  (rout),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Configuration writes; a new rate applies at once, on the current phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_rate <= lirs_pkg::RATE_RESET;
      dst_rate <= lirs_pkg::RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lirs_pkg::CFG_INPUT_RATE:  src_rate <= cfg_data;
        lirs_pkg::CFG_OUTPUT_RATE: dst_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: walk the phase, divide and interpolate per output (copy in the tail), then flush.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= '0;
      prev       <= '0;
      have_prev  <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      in_tail    <= 1'b0;
      eos        <= 1'b0;
      res_count  <= '0;
    end else begin
      // Raise valid for a new transfer, drop it once the current one completes.
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            cur       <= in_data.sample_in;
            eos       <= in_data.end_of_input;
            diff      <= {in_data.sample_in[S-1], in_data.sample_in} - {prev[S-1], prev};
            res_count <= '0;
            if (!have_prev) begin
              // First sample of a stream: store it, no segment yet.
              prev      <= in_data.sample_in;
              have_prev <= 1'b1;
              phase     <= '0;
              in_tail   <= in_data.end_of_input;
              state     <= in_data.end_of_input ? ST_TAIL : ST_IDLE;
            end else begin
              in_tail <= 1'b0;
              state   <= ST_RUN;
            end
          end
        end

        ST_RUN: begin
          if (below) begin
            // Advance phase now; the divider already latched the old value.
            phase <= phase_step;
            if (room) begin
              res_count <= res_count + NW'(1);
              state     <= ST_DIV;
            end
          end else begin
            phase   <= phase - PH'(rout);
            prev    <= cur;
            in_tail <= eos;
            state   <= eos ? ST_TAIL : ST_FLUSH;
          end
        end

        ST_DIV: begin
          if (div_done) begin
            prod  <= diff * $signed({1'b0, div_quot});
            state <= ST_RND;
          end
        end

        ST_RND: begin
          nv_sample <= prev + rshift[S-1:0];
          state     <= ST_PUSH;
        end

        ST_PUSH: begin
          if (!hold_valid) begin
            hold_sample <= nv_sample;
            hold_valid  <= 1'b1;
            state       <= in_tail ? ST_TAIL : ST_RUN;
          end else if (out_free) begin
            // A newer result exists, so the held one is not the run's last.
            out_data.sample_out  <= hold_sample;
            out_data.run_last    <= 1'b0;
            out_data.stream_done <= 1'b0;
            hold_sample          <= nv_sample;
            state                <= in_tail ? ST_TAIL : ST_RUN;
          end
        end

        ST_TAIL: begin
          if (below) begin
            phase <= phase_step;
            if (room) begin
              res_count <= res_count + NW'(1);
              nv_sample <= prev;
              state     <= ST_PUSH;
            end
          end else begin
            // End of stream: back to reset state, rates kept.
            prev      <= '0;
            have_prev <= 1'b0;
            phase     <= '0;
            state     <= ST_FLUSH;
          end
        end

        ST_FLUSH: begin
          if (!hold_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_data.sample_out  <= hold_sample;
            out_data.run_last    <= 1'b1;
            out_data.stream_done <= eos;
            hold_valid           <= 1'b0;
            state                <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // The held result is always flushed before the next item is taken.
  a_hold_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_valid)
    else $error("held result left over in idle");

  // Never more results per item than the run limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    res_count <= NW'(lirs_pkg::MAX_RUN))
    else $error("result count beyond run limit");

  // The divider only finishes while the sequencer waits on it.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

  // The stream's final transfer also closes its run.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stream_done) |-> out_data.run_last)
    else $error("stream_done without run_last");

endmodule
